>>> src/terminal_input_event_decoder_assert.svh
// assertion macros for the terminal input event decoder
`ifndef TERMINAL_INPUT_EVENT_DECODER_ASSERT_SVH
`define TERMINAL_INPUT_EVENT_DECODER_ASSERT_SVH

`ifndef SYNTHESIS
`define TIED_ASSERT(label, clock, rst_n, prop) \
	label: assert property (@(posedge clock) disable iff (!rst_n) prop) \
		else $error("assertion failed in terminal input event decoder");
`define TIED_ASSERT_ALWAYS(label, clock, prop) \
	label: assert property (@(posedge clock) prop) \
		else $error("assertion failed in terminal input event decoder");
`else
`define TIED_ASSERT(label, clock, rst_n, prop)
`define TIED_ASSERT_ALWAYS(label, clock, prop)
`endif

`endif

>>> src/tied_pkg.sv
// types and constants shared by the terminal input event decoder
`default_nettype none

package tied_pkg;

	localparam int BYTE_W  = 8;
	localparam int KIND_W  = 2;
	localparam int COORD_W = 7;
	localparam int MODS_W  = 5;
	localparam int PHASE_W = 3;

	localparam logic [BYTE_W-1:0] START_MOUSE_BYTE  = 8'h1e;
	localparam logic [BYTE_W-1:0] START_EXTKEY_BYTE = 8'h1f;

	localparam logic [PHASE_W-1:0] PH_IDLE    = 3'd0;
	localparam logic [PHASE_W-1:0] PH_EXT_MOD = 3'd1;
	localparam logic [PHASE_W-1:0] PH_EXT_KEY = 3'd2;
	localparam logic [PHASE_W-1:0] PH_MOUSE_X = 3'd3;
	localparam logic [PHASE_W-1:0] PH_MOUSE_Y = 3'd4;
	localparam logic [PHASE_W-1:0] PH_MOUSE_M = 3'd5;

	localparam logic [KIND_W-1:0] KIND_CHAR  = 2'd0;
	localparam logic [KIND_W-1:0] KIND_EXT   = 2'd1;
	localparam logic [KIND_W-1:0] KIND_MOUSE = 2'd2;

	typedef struct packed {
		logic [KIND_W-1:0]  kind;
		logic [BYTE_W-1:0]  key_code;
		logic [COORD_W-1:0] mouse_x;
		logic [COORD_W-1:0] mouse_y;
		logic               meta;
		logic               alt;
		logic               altgr;
		logic               ctrl;
		logic               shift;
		logic               middle;
		logic               right;
		logic               left;
	} tied_event_t;

endpackage

`default_nettype wire

>>> src/terminal_input_event_decoder.sv
// top level of the terminal input event decoder
//
// byte channel: byte_valid, byte_stall, in_byte; one request is one link byte
// event channel: event_valid, event_stall and one port per event field
// a byte is registered on entry and decoded against the parse phase in the
// next cycle; the finished event lands in the result register, so event_valid
// rises once the result register has loaded the event from the parser
// throughput is one byte per cycle while byte_stall is low, set by the parser update
// bytes that open or continue a sequence never wait on the event side
// when the receiver stalls, the result register holds its event and bytes
// that produce no event keep flowing; byte_stall rises only when the byte in
// the entry register would produce an event while the result register is
// full and stalled, and that byte waits there until the event is taken
// reset clears the parse phase, held modifiers and coordinates and empties
// both registers; fields an event does not use read as zero
`default_nettype none

module terminal_input_event_decoder
	import tied_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               byte_valid,
	output logic                    byte_stall,
	input  wire logic [BYTE_W-1:0]  in_byte,
	output logic                    event_valid,
	input  wire logic               event_stall,
	output logic [KIND_W-1:0]       event_kind,
	output logic [BYTE_W-1:0]       key_code,
	output logic [COORD_W-1:0]      mouse_x,
	output logic [COORD_W-1:0]      mouse_y,
	output logic                    mod_meta,
	output logic                    mod_alt,
	output logic                    mod_altgr,
	output logic                    mod_ctrl,
	output logic                    mod_shift,
	output logic                    btn_middle,
	output logic                    btn_right,
	output logic                    btn_left
);

	logic              valid_s1;
	logic [BYTE_W-1:0] byte_s1;
	logic              accept;
	logic              advance;
	logic              has_event;
	logic              out_free;
	tied_event_t       evt_dec;
	tied_event_t       evt_out;

	assign advance    = valid_s1 && (!has_event || out_free);
	assign byte_stall = valid_s1 && !advance;
	assign accept     = byte_valid && !byte_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept || (valid_s1 && !advance);
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			byte_s1 <= in_byte;
		end
	end

	tied_parser u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.data      (byte_s1),
		.fire      (advance),
		.has_event (has_event),
		.evt       (evt_dec)
	);

	tied_out_reg u_out_reg (
		.clk     (clk),
		.arst_n  (arst_n),
		.load    (advance && has_event),
		.evt_in  (evt_dec),
		.stall   (event_stall),
		.free    (out_free),
		.valid   (event_valid),
		.evt_out (evt_out)
	);

	assign event_kind = evt_out.kind;
	assign key_code   = evt_out.key_code;
	assign mouse_x    = evt_out.mouse_x;
	assign mouse_y    = evt_out.mouse_y;
	assign mod_meta   = evt_out.meta;
	assign mod_alt    = evt_out.alt;
	assign mod_altgr  = evt_out.altgr;
	assign mod_ctrl   = evt_out.ctrl;
	assign mod_shift  = evt_out.shift;
	assign btn_middle = evt_out.middle;
	assign btn_right  = evt_out.right;
	assign btn_left   = evt_out.left;

`include "terminal_input_event_decoder_assert.svh"

	`TIED_ASSERT(a_stall_only_when_full, clk, arst_n, byte_stall |-> (valid_s1 && event_valid && event_stall))
	`TIED_ASSERT(a_key_no_mouse_fields, clk, arst_n, (event_valid && event_kind != KIND_MOUSE) |-> (mouse_x == '0 && mouse_y == '0 && !btn_middle && !btn_right && !btn_left))
	`TIED_ASSERT(a_char_no_modifiers, clk, arst_n, (event_valid && event_kind == KIND_CHAR) |-> (!mod_meta && !mod_alt && !mod_altgr && !mod_ctrl && !mod_shift))
	`TIED_ASSERT(a_mouse_no_key_code, clk, arst_n, (event_valid && event_kind == KIND_MOUSE) |-> (key_code == '0 && !mod_altgr))

endmodule

`default_nettype wire

>>> src/tied_parser.sv
// sequence parser: phase and held fields, decodes one byte and flags whether it completes an event
`default_nettype none

module tied_parser
	import tied_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic [BYTE_W-1:0] data,
	input  wire logic              fire,
	output logic                   has_event,
	output tied_event_t            evt
);

	logic [PHASE_W-1:0] phase_q, phase_d;
	logic [MODS_W-1:0]  mods_q, mods_d;
	logic [COORD_W-1:0] x_q, x_d;
	logic [COORD_W-1:0] y_q, y_d;

	always_comb begin
		phase_d   = phase_q;
		mods_d    = mods_q;
		x_d       = x_q;
		y_d       = y_q;
		has_event = 1'b0;
		evt       = '0;
		unique case (phase_q)
			PH_EXT_MOD: begin
				mods_d  = data[MODS_W-1:0];
				phase_d = PH_EXT_KEY;
			end
			PH_EXT_KEY: begin
				has_event    = 1'b1;
				evt.kind     = KIND_EXT;
				evt.key_code = data;
				evt.meta     = mods_q[4];
				evt.alt      = mods_q[3];
				evt.altgr    = mods_q[2];
				evt.ctrl     = mods_q[1];
				evt.shift    = mods_q[0];
				phase_d      = PH_IDLE;
			end
			PH_MOUSE_X: begin
				x_d     = data[COORD_W-1:0];
				phase_d = PH_MOUSE_Y;
			end
			PH_MOUSE_Y: begin
				y_d     = data[COORD_W-1:0];
				phase_d = PH_MOUSE_M;
			end
			PH_MOUSE_M: begin
				has_event   = 1'b1;
				evt.kind    = KIND_MOUSE;
				evt.mouse_x = x_q;
				evt.mouse_y = y_q;
				evt.meta    = data[6];
				evt.alt     = data[5];
				evt.ctrl    = data[4];
				evt.shift   = data[3];
				evt.middle  = data[2];
				evt.right   = data[1];
				evt.left    = data[0];
				phase_d     = PH_IDLE;
			end
			default: begin
				priority if (data == START_MOUSE_BYTE) begin
					phase_d = PH_MOUSE_X;
				end else if (data == START_EXTKEY_BYTE) begin
					phase_d = PH_EXT_MOD;
				end else begin
					has_event    = 1'b1;
					evt.kind     = KIND_CHAR;
					evt.key_code = data;
					phase_d      = PH_IDLE;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			mods_q  <= '0;
			x_q     <= '0;
			y_q     <= '0;
		end else if (fire) begin
			phase_q <= phase_d;
			mods_q  <= mods_d;
			x_q     <= x_d;
			y_q     <= y_d;
		end
	end

endmodule

`default_nettype wire

>>> src/tied_out_reg.sv
// result register holding one decoded event for the receiver
`default_nettype none

module tied_out_reg
	import tied_pkg::*;
(
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         load,
	input  wire tied_event_t  evt_in,
	input  wire logic         stall,
	output logic              free,
	output logic              valid,
	output tied_event_t       evt_out
);

	logic        valid_q;
	tied_event_t evt_q;

	assign free    = !valid_q || !stall;
	assign valid   = valid_q;
	assign evt_out = evt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= load || (valid_q && stall);
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			evt_q <= evt_in;
		end
	end

endmodule

`default_nettype wire

>>> tb/sv/terminal_input_event_decoder_test.sv
// testbench for the terminal input event decoder: byte stream in, decoded events checked
module terminal_input_event_decoder_test;
	timeunit 1ns;
	timeprecision 1ps;
	import tied_pkg::*;

	localparam int CYCLE_LIMIT    = 400000;
	localparam int HOLD_OFF_LEN   = 200;
	localparam int BYTES_PER_MODE = 185;

	class input_event_board;
		logic [PHASE_W-1:0] phase;
		logic [MODS_W-1:0]  held_mods;
		logic [COORD_W-1:0] held_x;
		logic [COORD_W-1:0] held_y;
		tied_event_t        awaited_events[$];
		int                 mismatches;

		function new();
			phase = PH_IDLE;
			held_mods = '0;
			held_x = '0;
			held_y = '0;
			mismatches = 0;
		endfunction

		function void decode_byte(logic [BYTE_W-1:0] b);
			tied_event_t ev;
			bit emit;
			ev = '0;
			emit = 1'b0;
			case (phase)
				PH_EXT_MOD: begin
					held_mods = b[MODS_W-1:0];
					phase = PH_EXT_KEY;
				end
				PH_EXT_KEY: begin
					ev.kind = KIND_EXT;
					ev.key_code = b;
					ev.meta = held_mods[4];
					ev.alt = held_mods[3];
					ev.altgr = held_mods[2];
					ev.ctrl = held_mods[1];
					ev.shift = held_mods[0];
					emit = 1'b1;
					phase = PH_IDLE;
				end
				PH_MOUSE_X: begin
					held_x = b[COORD_W-1:0];
					phase = PH_MOUSE_Y;
				end
				PH_MOUSE_Y: begin
					held_y = b[COORD_W-1:0];
					phase = PH_MOUSE_M;
				end
				PH_MOUSE_M: begin
					ev.kind = KIND_MOUSE;
					ev.mouse_x = held_x;
					ev.mouse_y = held_y;
					ev.meta = b[6];
					ev.alt = b[5];
					ev.ctrl = b[4];
					ev.shift = b[3];
					ev.middle = b[2];
					ev.right = b[1];
					ev.left = b[0];
					emit = 1'b1;
					phase = PH_IDLE;
				end
				default: begin
					phase = PH_IDLE;
					if (b == START_MOUSE_BYTE) begin
						phase = PH_MOUSE_X;
					end else if (b == START_EXTKEY_BYTE) begin
						phase = PH_EXT_MOD;
					end else begin
						ev.kind = KIND_CHAR;
						ev.key_code = b;
						emit = 1'b1;
					end
				end
			endcase
			if (emit)
				awaited_events.push_back(ev);
		endfunction

		task report(string what);
			$display("[%0t] mismatch: %s", $realtime, what);
			mismatches++;
		endtask

		task compare_field(string name, logic [7:0] got, logic [7:0] want);
			if (got !== want)
				report($sformatf("%s got %0h expected %0h", name, got, want));
		endtask

		task check_event(tied_event_t got);
			tied_event_t want;
			if (awaited_events.size() == 0) begin
				report("event with none awaited");
			end else begin
				want = awaited_events.pop_front();
				compare_field("event_kind", 8'(got.kind), 8'(want.kind));
				compare_field("key_code", got.key_code, want.key_code);
				compare_field("mouse_x", 8'(got.mouse_x), 8'(want.mouse_x));
				compare_field("mouse_y", 8'(got.mouse_y), 8'(want.mouse_y));
				compare_field("mod_meta", 8'(got.meta), 8'(want.meta));
				compare_field("mod_alt", 8'(got.alt), 8'(want.alt));
				compare_field("mod_altgr", 8'(got.altgr), 8'(want.altgr));
				compare_field("mod_ctrl", 8'(got.ctrl), 8'(want.ctrl));
				compare_field("mod_shift", 8'(got.shift), 8'(want.shift));
				compare_field("btn_middle", 8'(got.middle), 8'(want.middle));
				compare_field("btn_right", 8'(got.right), 8'(want.right));
				compare_field("btn_left", 8'(got.left), 8'(want.left));
			end
		endtask
	endclass

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               byte_valid = 1'b0;
	logic [BYTE_W-1:0]  in_byte = '0;
	logic               event_stall = 1'b0;
	logic               byte_stall;
	logic               event_valid;
	logic [KIND_W-1:0]  event_kind;
	logic [BYTE_W-1:0]  key_code;
	logic [COORD_W-1:0] mouse_x;
	logic [COORD_W-1:0] mouse_y;
	logic               mod_meta;
	logic               mod_alt;
	logic               mod_altgr;
	logic               mod_ctrl;
	logic               mod_shift;
	logic               btn_middle;
	logic               btn_right;
	logic               btn_left;

	input_event_board board = new();
	tied_event_t      seen_event;
	int               send_idle_pct = 0;
	int               stall_pct = 0;
	bit               hold_off_request = 1'b0;
	int               bytes_sent = 0;
	int               cycle_count = 0;

	terminal_input_event_decoder dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.byte_valid (byte_valid),
		.byte_stall (byte_stall),
		.in_byte    (in_byte),
		.event_valid(event_valid),
		.event_stall(event_stall),
		.event_kind (event_kind),
		.key_code   (key_code),
		.mouse_x    (mouse_x),
		.mouse_y    (mouse_y),
		.mod_meta   (mod_meta),
		.mod_alt    (mod_alt),
		.mod_altgr  (mod_altgr),
		.mod_ctrl   (mod_ctrl),
		.mod_shift  (mod_shift),
		.btn_middle (btn_middle),
		.btn_right  (btn_right),
		.btn_left   (btn_left)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && event_valid && !event_stall) begin
			seen_event.kind = event_kind;
			seen_event.key_code = key_code;
			seen_event.mouse_x = mouse_x;
			seen_event.mouse_y = mouse_y;
			seen_event.meta = mod_meta;
			seen_event.alt = mod_alt;
			seen_event.altgr = mod_altgr;
			seen_event.ctrl = mod_ctrl;
			seen_event.shift = mod_shift;
			seen_event.middle = btn_middle;
			seen_event.right = btn_right;
			seen_event.left = btn_left;
			board.check_event(seen_event);
		end
	end

	// receiver side, with a long hold-off on request
	initial begin
		forever begin
			@(negedge clk);
			if (hold_off_request) begin
				hold_off_request = 1'b0;
				event_stall = 1'b1;
				repeat (HOLD_OFF_LEN) @(negedge clk);
			end
			event_stall = ($urandom_range(99) < stall_pct);
		end
	end

	// entered and left at a falling edge
	task send_byte(input logic [BYTE_W-1:0] b);
		while ($urandom_range(99) < send_idle_pct) begin
			byte_valid = 1'b0;
			@(negedge clk);
		end
		byte_valid = 1'b1;
		in_byte = b;
		do
			@(posedge clk);
		while (byte_stall);
		board.decode_byte(b);
		bytes_sent++;
		@(negedge clk);
	endtask

	task send_sequence();
		logic [BYTE_W-1:0] b;
		case ($urandom_range(9))
			0, 1, 2: begin
				b = 8'($urandom_range(255));
				if (b == START_MOUSE_BYTE || b == START_EXTKEY_BYTE)
					b = b ^ 8'h80;
				send_byte(b);
			end
			3, 4, 5: begin
				send_byte(START_EXTKEY_BYTE);
				send_byte(8'($urandom_range(255)));
				send_byte(8'($urandom_range(255)));
			end
			6, 7, 8: begin
				send_byte(START_MOUSE_BYTE);
				send_byte(8'($urandom_range(255)));
				send_byte(8'($urandom_range(255)));
				send_byte(8'($urandom_range(255)));
			end
			default: begin
				// stray byte, may open or cut into a sequence
				send_byte(8'($urandom_range(255)));
			end
		endcase
	endtask

	initial begin
		int target;
		repeat (2) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// plain characters at the extremes
		send_byte(8'h00);
		send_byte(8'hff);
		send_byte(8'h41);
		// extended key, start byte as key code, all modifiers
		send_byte(START_EXTKEY_BYTE);
		send_byte(8'hff);
		send_byte(START_MOUSE_BYTE);
		// extended key with only the unused modifier bits
		send_byte(START_EXTKEY_BYTE);
		send_byte(8'he0);
		send_byte(START_EXTKEY_BYTE);
		// mouse with start bytes as coordinates
		send_byte(START_MOUSE_BYTE);
		send_byte(START_MOUSE_BYTE);
		send_byte(START_EXTKEY_BYTE);
		send_byte(8'h7f);
		// mouse, top bits dropped
		send_byte(START_MOUSE_BYTE);
		send_byte(8'hff);
		send_byte(8'h80);
		send_byte(8'h80);
		send_byte(START_MOUSE_BYTE);
		send_byte(8'h00);
		send_byte(8'h7f);
		send_byte(8'h00);

		target = bytes_sent;
		for (int mode = 0; mode < 4; mode++) begin
			case (mode)
				0: begin send_idle_pct = 0;  stall_pct = 0;  end
				1: begin send_idle_pct = 77; stall_pct = 0;  end
				2: begin send_idle_pct = 0;  stall_pct = 77; end
				default: begin send_idle_pct = 36; stall_pct = 36; end
			endcase
			target += BYTES_PER_MODE;
			while (bytes_sent < target)
				send_sequence();
			if (mode == 0) begin
				// back-pressure until the input stalls
				hold_off_request = 1'b1;
				for (int i = 0; i < 24; i++)
					send_byte(8'h20 + 8'(i));
			end
		end

		byte_valid = 1'b0;
		stall_pct = 0;
		while (board.awaited_events.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
		if (board.mismatches == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
